// ===== rtl/core/qaar_pkg.sv =====
// shared types, constants and tables for the quaternion axis-angle rotator
`default_nettype none
package qaar_pkg;

   localparam int CoordW = 32;
   localparam int AngleW = 24;
   localparam int CordicStagesDef = 20;
   localparam int CordicTableLen = 30;
   localparam int CordicW = 34;
   localparam int RootW = 32;
   localparam int SumW = 2 * RootW;
   localparam int QuotW = 31;
   localparam int FracBits = 30;
   localparam int ProdW = 72;
   localparam int RndW = ProdW - FracBits;

   localparam logic signed [CordicW-1:0] OneQ30 = 34'sd1073741824;
   localparam logic signed [CordicW-1:0] PiQ30 = 34'sd3373259426;
   localparam logic signed [CordicW-1:0] HalfPiQ30 = 34'sd1686629713;
   localparam logic signed [CordicW-1:0] GainQ30 = 34'sd652032874;

   typedef struct packed {
      logic signed [CoordW-1:0] axis_x;
      logic signed [CoordW-1:0] axis_y;
      logic signed [CoordW-1:0] axis_z;
      logic signed [CoordW-1:0] vec_x;
      logic signed [CoordW-1:0] vec_y;
      logic signed [CoordW-1:0] vec_z;
      logic signed [AngleW-1:0] turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] rot_x;
      logic signed [CoordW-1:0] rot_y;
      logic signed [CoordW-1:0] rot_z;
      logic                     axis_zero;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [2:0]               neg;
      logic                     zero;
      logic signed [CoordW-1:0] vec_x;
      logic signed [CoordW-1:0] vec_y;
      logic signed [CoordW-1:0] vec_z;
   } carry_type;

   typedef struct packed {
      logic [SumW-1:0]          sum;
      logic [2:0][CoordW-1:0]   mag;
      carry_type                carry;
   } cord_side_type;

   typedef struct packed {
      logic [2:0][CoordW-1:0]   mag;
      carry_type                carry;
      logic signed [CordicW-1:0] cos_h;
      logic signed [CordicW-1:0] sin_h;
   } root_side_type;

   typedef struct packed {
      carry_type                carry;
      logic signed [CordicW-1:0] cos_h;
      logic signed [CordicW-1:0] sin_h;
   } div_side_type;

   function automatic logic signed [CordicW-1:0] atan_q30(input int unsigned idx);
      case (idx)
         0: atan_q30 = 34'sd843314856;
         1: atan_q30 = 34'sd497837829;
         2: atan_q30 = 34'sd263043836;
         3: atan_q30 = 34'sd133525158;
         4: atan_q30 = 34'sd67021686;
         5: atan_q30 = 34'sd33543515;
         6: atan_q30 = 34'sd16775850;
         7: atan_q30 = 34'sd8388437;
         8: atan_q30 = 34'sd4194282;
         9: atan_q30 = 34'sd2097149;
         10: atan_q30 = 34'sd1048575;
         11: atan_q30 = 34'sd524287;
         12: atan_q30 = 34'sd262143;
         13: atan_q30 = 34'sd131071;
         14: atan_q30 = 34'sd65535;
         15: atan_q30 = 34'sd32767;
         16: atan_q30 = 34'sd16383;
         17: atan_q30 = 34'sd8191;
         18: atan_q30 = 34'sd4095;
         19: atan_q30 = 34'sd2047;
         20: atan_q30 = 34'sd1023;
         21: atan_q30 = 34'sd511;
         22: atan_q30 = 34'sd255;
         23: atan_q30 = 34'sd127;
         24: atan_q30 = 34'sd63;
         25: atan_q30 = 34'sd31;
         26: atan_q30 = 34'sd15;
         27: atan_q30 = 34'sd8;
         28: atan_q30 = 34'sd4;
         29: atan_q30 = 34'sd2;
         default: atan_q30 = '0;
      endcase
   endfunction

   // round to nearest, half up, dropping the q30 fraction
   function automatic logic signed [RndW-1:0] rnd_q30(input logic signed [ProdW-1:0] v);
      logic signed [ProdW-1:0] t;
      t = v + (ProdW'(1) <<< (FracBits - 1));
      rnd_q30 = RndW'(t >>> FracBits);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/qaar_prep.sv =====
// axis preparation: magnitudes, normalising shift, sum of squares, half angle reduction
`default_nettype none
module qaar_prep (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  qaar_pkg::req_type                        in_data,
   output logic                                     out_valid,
   output logic signed [qaar_pkg::CordicW-1:0]      h_out,
   output qaar_pkg::cord_side_type                  side_out
);

   localparam int W = qaar_pkg::CordicW;
   localparam int CW = qaar_pkg::CoordW;
   localparam int NStg = 6;

   logic [NStg-1:0] valid_ff;

   logic signed [W-1:0] h1_ff, h2_ff, h3_ff, h4_ff, h5_ff, h6_ff;
   qaar_pkg::carry_type carry1_ff, carry2_ff, carry3_ff, carry4_ff, carry5_ff, carry6_ff;
   logic [2:0][CW-1:0] mag1_ff, mag2_ff, mag3_ff, mag4_ff, mag5_ff, mag6_ff;
   logic [CW-1:0] max1_ff;
   logic [3:0] nz2_ff;
   logic [3:0][2:0] lz2_ff;
   logic [4:0] sh3_ff;
   logic [2:0][qaar_pkg::SumW-1:0] sq5_ff;
   logic [qaar_pkg::SumW-1:0] sum6_ff;

   logic [2:0][CW-1:0] mag1_in, mag4_in;
   logic [CW-1:0] max1_in;
   logic signed [W-1:0] h_ext, h1_in;
   qaar_pkg::carry_type carry1_in;
   logic [3:0] nz2_in;
   logic [3:0][2:0] lz2_in;
   logic [5:0] lzc;
   logic [4:0] sh3_in;
   logic [2:0][qaar_pkg::SumW-1:0] sq5_in;
   logic signed [CW-1:0] axis [3];

   // stage 1: magnitudes, largest, half angle
   always_comb begin
      axis[0] = in_data.axis_x;
      axis[1] = in_data.axis_y;
      axis[2] = in_data.axis_z;
      for (int l = 0; l < 3; l++) begin
         mag1_in[l] = axis[l][CW-1] ? (~axis[l] + CW'(1)) : axis[l];
         carry1_in.neg[l] = axis[l][CW-1];
      end
      max1_in = mag1_in[0];
      if (mag1_in[1] > max1_in) begin
         max1_in = mag1_in[1];
      end
      if (mag1_in[2] > max1_in) begin
         max1_in = mag1_in[2];
      end
      carry1_in.zero = (in_data.axis_x == '0) && (in_data.axis_y == '0) &&
                       (in_data.axis_z == '0);
      carry1_in.vec_x = in_data.vec_x;
      carry1_in.vec_y = in_data.vec_y;
      carry1_in.vec_z = in_data.vec_z;
      h_ext = {{(W - qaar_pkg::AngleW - 9){in_data.turn_angle[qaar_pkg::AngleW-1]}},
               in_data.turn_angle, 9'b0};
      if (h_ext > qaar_pkg::HalfPiQ30) begin
         h1_in = h_ext - qaar_pkg::PiQ30;
      end else if (h_ext < -qaar_pkg::HalfPiQ30) begin
         h1_in = h_ext + qaar_pkg::PiQ30;
      end else begin
         h1_in = h_ext;
      end
   end

   // stage 2: leading zeros per byte
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         nz2_in[c] = |max1_ff[CW-1-8*c -: 8];
         lz2_in[c] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (max1_ff[CW-8-8*c+b]) begin
               lz2_in[c] = 3'(7 - b);
            end
         end
      end
   end

   // stage 3: shift amount so the largest lands in [2^30, 2^31]
   always_comb begin
      lzc = 6'd0;
      for (int c = 3; c >= 0; c--) begin
         if (nz2_ff[c]) begin
            lzc = 6'(8 * c) + {3'b0, lz2_ff[c]};
         end
      end
      sh3_in = (lzc == 6'd0) ? 5'd0 : 5'(lzc - 6'd1);
   end

   // stage 4 and 5: shift and square
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag4_in[l] = mag3_ff[l] << sh3_ff;
         sq5_in[l] = mag4_ff[l] * mag4_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NStg-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h1_ff <= h1_in;
         carry1_ff <= carry1_in;
         mag1_ff <= mag1_in;
         max1_ff <= max1_in;
         h2_ff <= h1_ff;
         carry2_ff <= carry1_ff;
         mag2_ff <= mag1_ff;
         nz2_ff <= nz2_in;
         lz2_ff <= lz2_in;
         h3_ff <= h2_ff;
         carry3_ff <= carry2_ff;
         mag3_ff <= mag2_ff;
         sh3_ff <= sh3_in;
         h4_ff <= h3_ff;
         carry4_ff <= carry3_ff;
         mag4_ff <= mag4_in;
         h5_ff <= h4_ff;
         carry5_ff <= carry4_ff;
         mag5_ff <= mag4_ff;
         sq5_ff <= sq5_in;
         h6_ff <= h5_ff;
         carry6_ff <= carry5_ff;
         mag6_ff <= mag5_ff;
         sum6_ff <= sq5_ff[0] + sq5_ff[1] + sq5_ff[2];
      end
   end

   assign out_valid = valid_ff[NStg-1];
   assign h_out = h6_ff;
   assign side_out.sum = sum6_ff;
   assign side_out.mag = mag6_ff;
   assign side_out.carry = carry6_ff;

endmodule
`default_nettype wire

// ===== rtl/core/qaar_cordic.sv =====
// pipelined rotation-mode cordic giving cosine and sine of the half angle
`default_nettype none
module qaar_cordic #(
   parameter int Stages = qaar_pkg::CordicStagesDef,
   parameter int SideW = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [qaar_pkg::CordicW-1:0] h_in,
   input  logic [SideW-1:0]                    side_in,
   output logic                                out_valid,
   output logic signed [qaar_pkg::CordicW-1:0] cos_out,
   output logic signed [qaar_pkg::CordicW-1:0] sin_out,
   output logic [SideW-1:0]                    side_out
);

   localparam int W = qaar_pkg::CordicW;

   logic                valid_ff [Stages];
   logic signed [W-1:0] x_ff [Stages];
   logic signed [W-1:0] y_ff [Stages];
   logic signed [W-1:0] z_ff [Stages];
   logic [SideW-1:0]    side_ff [Stages];

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      localparam logic signed [W-1:0] Atan = qaar_pkg::atan_q30(k);
      logic                vs;
      logic signed [W-1:0] xs, ys, zs, x_in, y_in, z_in;
      logic [SideW-1:0]    ss;

      if (k == 0) begin : g_first
         assign vs = in_valid;
         assign xs = qaar_pkg::GainQ30;
         assign ys = '0;
         assign zs = h_in;
         assign ss = side_in;
      end else begin : g_next
         assign vs = valid_ff[k-1];
         assign xs = x_ff[k-1];
         assign ys = y_ff[k-1];
         assign zs = z_ff[k-1];
         assign ss = side_ff[k-1];
      end

      always_comb begin
         if (zs >= 0) begin
            x_in = xs - (ys >>> k);
            y_in = ys + (xs >>> k);
            z_in = zs - Atan;
         end else begin
            x_in = xs + (ys >>> k);
            y_in = ys - (xs >>> k);
            z_in = zs + Atan;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[k] <= x_in;
            y_ff[k] <= y_in;
            z_ff[k] <= z_in;
            side_ff[k] <= ss;
         end
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign cos_out = x_ff[Stages-1];
   assign sin_out = y_ff[Stages-1];
   assign side_out = side_ff[Stages-1];

endmodule
`default_nettype wire

// ===== rtl/core/qaar_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module qaar_sqrt #(
   parameter int SideW = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [qaar_pkg::SumW-1:0]      n_in,
   input  logic [SideW-1:0]               side_in,
   output logic                           out_valid,
   output logic [qaar_pkg::RootW-1:0]     root_out,
   output logic [SideW-1:0]               side_out
);

   localparam int RW = qaar_pkg::RootW;
   localparam int NW = qaar_pkg::SumW;
   localparam int RemW = RW + 4;

   logic             valid_ff [RW];
   logic [RemW-1:0]  rem_ff [RW];
   logic [RW-1:0]    root_ff [RW];
   logic [NW-1:0]    n_ff [RW];
   logic [SideW-1:0] side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic             vs;
      logic [RemW-1:0]  rs, r2, trial, rem_in;
      logic [RW-1:0]    qs, root_in;
      logic [NW-1:0]    ns;
      logic [SideW-1:0] ss;

      if (k == 0) begin : g_first
         assign vs = in_valid;
         assign rs = '0;
         assign qs = '0;
         assign ns = n_in;
         assign ss = side_in;
      end else begin : g_next
         assign vs = valid_ff[k-1];
         assign rs = rem_ff[k-1];
         assign qs = root_ff[k-1];
         assign ns = n_ff[k-1];
         assign ss = side_ff[k-1];
      end

      always_comb begin
         r2 = {rs[RemW-3:0], ns[NW-1 -: 2]};
         trial = {2'b0, qs, 2'b01};
         if (r2 >= trial) begin
            rem_in = r2 - trial;
            root_in = {qs[RW-2:0], 1'b1};
         end else begin
            rem_in = r2;
            root_in = {qs[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            root_ff[k] <= root_in;
            n_ff[k] <= {ns[NW-3:0], 2'b00};
            side_ff[k] <= ss;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign root_out = root_ff[RW-1];
   assign side_out = side_ff[RW-1];

endmodule
`default_nettype wire

// ===== rtl/core/qaar_div.sv =====
// three-lane pipelined restoring divider for the unit axis, rounded half up
`default_nettype none
module qaar_div #(
   parameter int SideW = 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  logic [qaar_pkg::RootW-1:0]               len_in,
   input  logic [2:0][qaar_pkg::CoordW-1:0]         mag_in,
   input  logic [SideW-1:0]                         side_in,
   output logic                                     out_valid,
   output logic [2:0][qaar_pkg::QuotW-1:0]          quot_out,
   output logic [SideW-1:0]                         side_out
);

   localparam int LW = qaar_pkg::RootW;
   localparam int QW = qaar_pkg::QuotW;
   localparam int FB = qaar_pkg::FracBits;
   localparam int NumW = qaar_pkg::CoordW + FB;

   logic                  pvalid_ff;
   logic [LW-1:0]         plen_ff;
   logic [2:0][LW-1:0]    prem_ff;
   logic [2:0][QW-1:0]    plow_ff;
   logic [SideW-1:0]      pside_ff;
   logic [NumW-1:0]       num [3];

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         num[l] = {mag_in[l], FB'(0)} + NumW'(len_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else if (adv) begin
         pvalid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plen_ff <= len_in;
         pside_ff <= side_in;
         for (int l = 0; l < 3; l++) begin
            prem_ff[l] <= LW'(num[l][NumW-1:QW]);
            plow_ff[l] <= num[l][QW-1:0];
         end
      end
   end

   logic               valid_ff [QW];
   logic [LW-1:0]      len_ff [QW];
   logic [2:0][LW-1:0] rem_ff [QW];
   logic [2:0][QW-1:0] low_ff [QW];
   logic [2:0][QW-1:0] quot_ff [QW];
   logic [SideW-1:0]   side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic               vs;
      logic [LW-1:0]      ls;
      logic [2:0][LW-1:0] rs, rem_in;
      logic [2:0][QW-1:0] lows, qs, quot_in, low_in;
      logic [SideW-1:0]   ss;
      logic [LW:0]        r2 [3];

      if (k == 0) begin : g_first
         assign vs = pvalid_ff;
         assign ls = plen_ff;
         assign rs = prem_ff;
         assign lows = plow_ff;
         assign qs = '0;
         assign ss = pside_ff;
      end else begin : g_next
         assign vs = valid_ff[k-1];
         assign ls = len_ff[k-1];
         assign rs = rem_ff[k-1];
         assign lows = low_ff[k-1];
         assign qs = quot_ff[k-1];
         assign ss = side_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            r2[l] = {rs[l], lows[l][QW-1]};
            low_in[l] = {lows[l][QW-2:0], 1'b0};
            if (r2[l] >= {1'b0, ls}) begin
               rem_in[l] = LW'(r2[l] - {1'b0, ls});
               quot_in[l] = {qs[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = r2[l][LW-1:0];
               quot_in[l] = {qs[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            len_ff[k] <= ls;
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_in;
            quot_ff[k] <= quot_in;
            side_ff[k] <= ss;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quot_out = quot_ff[QW-1];
   assign side_out = side_ff[QW-1];

endmodule
`default_nettype wire

// ===== rtl/core/qaar_rotate.sv =====
// quaternion to rotation matrix, matrix times vector, rounding and clipping
`default_nettype none
module qaar_rotate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [2:0][qaar_pkg::QuotW-1:0]     quot_in,
   input  qaar_pkg::div_side_type              side_in,
   output logic                                out_valid,
   output qaar_pkg::rsp_type                   out_data
);

   localparam int W = qaar_pkg::CordicW;
   localparam int CW = qaar_pkg::CoordW;
   localparam int PW = qaar_pkg::ProdW;
   localparam int RW = qaar_pkg::RndW;
   localparam int MW = W + 2;
   localparam int P1W = W + CW;
   localparam int P2W = 2 * W;
   localparam int P4W = MW + CW;

   // product slots
   localparam int IdxXX = 0;
   localparam int IdxYY = 1;
   localparam int IdxZZ = 2;
   localparam int IdxXY = 3;
   localparam int IdxXZ = 4;
   localparam int IdxYZ = 5;
   localparam int IdxWX = 6;
   localparam int IdxWY = 7;
   localparam int IdxWZ = 8;

   logic [4:0] valid_ff;
   qaar_pkg::carry_type carry1_ff, carry2_ff, carry3_ff, carry4_ff;
   logic signed [W-1:0] w1_ff;
   logic signed [P1W-1:0] p1_ff [3];
   logic signed [P2W-1:0] p2_ff [9];
   logic signed [MW-1:0] m3_ff [3][3];
   logic signed [P4W-1:0] p4_ff [3][3];
   qaar_pkg::rsp_type out_ff;

   logic signed [CW-1:0] u [3];
   logic signed [P1W-1:0] p1_in [3];
   logic signed [W-1:0] b [3];
   logic signed [P2W-1:0] p2_in [9];
   logic signed [MW-1:0] e [9];
   logic signed [MW-1:0] m3_in [3][3];
   logic signed [CW-1:0] v [3];
   logic signed [P4W-1:0] p4_in [3][3];
   logic signed [PW-1:0] acc [3];
   logic signed [RW-1:0] r [3];
   logic signed [CW-1:0] c [3];
   logic [2:0] sat;
   qaar_pkg::rsp_type out_in;

   // stage 1: sine times unit axis
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         u[l] = side_in.carry.neg[l] ? -$signed({1'b0, quot_in[l]}) : $signed({1'b0, quot_in[l]});
         p1_in[l] = side_in.sin_h * u[l];
      end
   end

   // stage 2: quaternion products
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         b[l] = W'(qaar_pkg::rnd_q30(PW'(p1_ff[l])));
      end
      p2_in[IdxXX] = b[0] * b[0];
      p2_in[IdxYY] = b[1] * b[1];
      p2_in[IdxZZ] = b[2] * b[2];
      p2_in[IdxXY] = b[0] * b[1];
      p2_in[IdxXZ] = b[0] * b[2];
      p2_in[IdxYZ] = b[1] * b[2];
      p2_in[IdxWX] = w1_ff * b[0];
      p2_in[IdxWY] = w1_ff * b[1];
      p2_in[IdxWZ] = w1_ff * b[2];
   end

   // stage 3: rotation matrix
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = MW'(qaar_pkg::rnd_q30(PW'(p2_ff[i])));
      end
      m3_in[0][0] = MW'(qaar_pkg::OneQ30) - ((e[IdxYY] + e[IdxZZ]) <<< 1);
      m3_in[0][1] = (e[IdxXY] - e[IdxWZ]) <<< 1;
      m3_in[0][2] = (e[IdxXZ] + e[IdxWY]) <<< 1;
      m3_in[1][0] = (e[IdxXY] + e[IdxWZ]) <<< 1;
      m3_in[1][1] = MW'(qaar_pkg::OneQ30) - ((e[IdxXX] + e[IdxZZ]) <<< 1);
      m3_in[1][2] = (e[IdxYZ] - e[IdxWX]) <<< 1;
      m3_in[2][0] = (e[IdxXZ] - e[IdxWY]) <<< 1;
      m3_in[2][1] = (e[IdxYZ] + e[IdxWX]) <<< 1;
      m3_in[2][2] = MW'(qaar_pkg::OneQ30) - ((e[IdxXX] + e[IdxYY]) <<< 1);
   end

   // stage 4: matrix times vector
   always_comb begin
      v[0] = carry3_ff.vec_x;
      v[1] = carry3_ff.vec_y;
      v[2] = carry3_ff.vec_z;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p4_in[i][j] = m3_ff[i][j] * v[j];
         end
      end
   end

   // stage 5: sum, round, clip
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = PW'(p4_ff[i][0]) + PW'(p4_ff[i][1]) + PW'(p4_ff[i][2]);
         r[i] = qaar_pkg::rnd_q30(acc[i]);
         if (r[i] > RW'(64'sd2147483647)) begin
            c[i] = {1'b0, {(CW-1){1'b1}}};
            sat[i] = 1'b1;
         end else if (r[i] < -RW'(64'sd2147483648)) begin
            c[i] = {1'b1, {(CW-1){1'b0}}};
            sat[i] = 1'b1;
         end else begin
            c[i] = r[i][CW-1:0];
            sat[i] = 1'b0;
         end
      end
      if (carry4_ff.zero) begin
         out_in.rot_x = carry4_ff.vec_x;
         out_in.rot_y = carry4_ff.vec_y;
         out_in.rot_z = carry4_ff.vec_z;
         out_in.axis_zero = 1'b1;
         out_in.saturated = 1'b0;
      end else begin
         out_in.rot_x = c[0];
         out_in.rot_y = c[1];
         out_in.rot_z = c[2];
         out_in.axis_zero = 1'b0;
         out_in.saturated = |sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry1_ff <= side_in.carry;
         w1_ff <= side_in.cos_h;
         p1_ff <= p1_in;
         carry2_ff <= carry1_ff;
         p2_ff <= p2_in;
         carry3_ff <= carry2_ff;
         m3_ff <= m3_in;
         carry4_ff <= carry3_ff;
         p4_ff <= p4_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data = out_ff;

endmodule
`default_nettype wire

// ===== rtl/core/quaternion_axis_angle_rotate.sv =====
// top level: rotates a vector about an arbitrary axis through a quaternion
// pipeline order: axis preparation, cordic stages, the one-bit-per-stage square root and
//   divider, then the rotation stages
// throughput: one request per cycle; the whole pipeline holds when the result is not taken
// reset clears the valid bits only; the block keeps no other state
`default_nettype none
module quaternion_axis_angle_rotate #(
   parameter int CordicStages = qaar_pkg::CordicStagesDef
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qaar_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qaar_pkg::rsp_type    rsp_data
);

   localparam int CordSideW = $bits(qaar_pkg::cord_side_type);
   localparam int RootSideW = $bits(qaar_pkg::root_side_type);
   localparam int DivSideW = $bits(qaar_pkg::div_side_type);

   logic adv;
   logic prep_valid, cord_valid, root_valid, div_valid;
   logic signed [qaar_pkg::CordicW-1:0] h;
   logic signed [qaar_pkg::CordicW-1:0] cos_h, sin_h;
   qaar_pkg::cord_side_type prep_side, cord_side;
   qaar_pkg::root_side_type root_side_in, root_side;
   qaar_pkg::div_side_type div_side_in, div_side;
   logic [CordSideW-1:0] cord_side_vec;
   logic [RootSideW-1:0] root_side_vec;
   logic [DivSideW-1:0] div_side_vec;
   logic [qaar_pkg::RootW-1:0] len;
   logic [2:0][qaar_pkg::QuotW-1:0] quot;

   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   qaar_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .h_out     (h),
      .side_out  (prep_side)
   );

   qaar_cordic #(
      .Stages (CordicStages),
      .SideW  (CordSideW)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (prep_valid),
      .h_in      (h),
      .side_in   (prep_side),
      .out_valid (cord_valid),
      .cos_out   (cos_h),
      .sin_out   (sin_h),
      .side_out  (cord_side_vec)
   );

   assign cord_side = cord_side_vec;
   assign root_side_in.mag = cord_side.mag;
   assign root_side_in.carry = cord_side.carry;
   assign root_side_in.cos_h = cos_h;
   assign root_side_in.sin_h = sin_h;

   qaar_sqrt #(
      .SideW (RootSideW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cord_valid),
      .n_in      (cord_side.sum),
      .side_in   (root_side_in),
      .out_valid (root_valid),
      .root_out  (len),
      .side_out  (root_side_vec)
   );

   assign root_side = root_side_vec;
   assign div_side_in.carry = root_side.carry;
   assign div_side_in.cos_h = root_side.cos_h;
   assign div_side_in.sin_h = root_side.sin_h;

   qaar_div #(
      .SideW (DivSideW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (root_valid),
      .len_in    (len),
      .mag_in    (root_side.mag),
      .side_in   (div_side_in),
      .out_valid (div_valid),
      .quot_out  (quot),
      .side_out  (div_side_vec)
   );

   assign div_side = div_side_vec;

   qaar_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .quot_in   (quot),
      .side_in   (div_side),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/quaternion_axis_angle_rotate_tb.sv =====
// testbench for the quaternion axis-angle rotator: directed and random requests checked by a scoreboard
`default_nettype none
module quaternion_axis_angle_rotate_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Stages = 20;
   localparam int Latency = Stages + 75;
   localparam int IdleLimit = 4000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   qaar_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   qaar_pkg::rsp_type rsp_data;

   int      rsp_stall_pct;
   int      idle_count;
   int      sat_seen;
   int      zero_seen;

   quaternion_axis_angle_rotate #(.CordicStages(Stages)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   class rotation_scoreboard;
      qaar_pkg::rsp_type pending[$];
      int      errors;
      int      checked;
      longint  atan_tab[30] = '{
         843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
         16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
         65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
         15, 8, 4, 2};

      function longint round_q30(longint v);
         return (v + (longint'(1) << 29)) >>> 30;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res, bits;
         res = 0;
         bits = longint'(1) << 62;
         while (bits > n) bits = bits >> 2;
         while (bits != 0) begin
            if (n >= res + bits) begin
               n = n - (res + bits);
               res = (res >> 1) + bits;
            end else begin
               res = res >> 1;
            end
            bits = bits >> 2;
         end
         return res;
      endfunction

      function qaar_pkg::rsp_type rotate(qaar_pkg::req_type rq);
         qaar_pkg::rsp_type r;
         longint a[3], v[3], u[3], m[3][3], acc, h, cx, cy, cz, dx, dy, w;
         longint b[3], xx, yy, zz, xy, xz, yz, wx, wy, wz;
         longint unsigned mag[3], mx, sum, len, q;
         a[0] = rq.axis_x; a[1] = rq.axis_y; a[2] = rq.axis_z;
         v[0] = rq.vec_x;  v[1] = rq.vec_y;  v[2] = rq.vec_z;
         h = longint'(rq.turn_angle) * 512;
         r = '0;
         if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
            r.rot_x = rq.vec_x; r.rot_y = rq.vec_y; r.rot_z = rq.vec_z;
            r.axis_zero = 1'b1;
            return r;
         end
         mx = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = a[i] < 0 ? -a[i] : a[i];
            if (mag[i] > mx) mx = mag[i];
         end
         while (mx < (longint'(1) << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         len = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            u[i] = a[i] < 0 ? -longint'(q) : longint'(q);
         end
         if (h > 64'sd1686629713) h = h - 64'sd3373259426;
         else if (h < -64'sd1686629713) h = h + 64'sd3373259426;
         cx = 652032874;
         cy = 0;
         cz = h;
         for (int i = 0; i < Stages && i < 30; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
               cx = cx - dx; cy = cy + dy; cz = cz - atan_tab[i];
            end else begin
               cx = cx + dx; cy = cy - dy; cz = cz + atan_tab[i];
            end
         end
         w = cx;
         for (int i = 0; i < 3; i++) b[i] = round_q30(cy * u[i]);
         xx = round_q30(b[0] * b[0]); yy = round_q30(b[1] * b[1]);
         zz = round_q30(b[2] * b[2]); xy = round_q30(b[0] * b[1]);
         xz = round_q30(b[0] * b[2]); yz = round_q30(b[1] * b[2]);
         wx = round_q30(w * b[0]); wy = round_q30(w * b[1]); wz = round_q30(w * b[2]);
         m[0][0] = 1073741824 - 2 * (yy + zz);
         m[0][1] = 2 * (xy - wz);
         m[0][2] = 2 * (xz + wy);
         m[1][0] = 2 * (xy + wz);
         m[1][1] = 1073741824 - 2 * (xx + zz);
         m[1][2] = 2 * (yz - wx);
         m[2][0] = 2 * (xz - wy);
         m[2][1] = 2 * (yz + wx);
         m[2][2] = 1073741824 - 2 * (xx + yy);
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc = acc + m[i][j] * v[j];
            acc = round_q30(acc);
            if (acc > 64'sd2147483647) begin
               acc = 64'sd2147483647; r.saturated = 1'b1;
            end else if (acc < -64'sd2147483648) begin
               acc = -64'sd2147483648; r.saturated = 1'b1;
            end
            if (i == 0) r.rot_x = acc[31:0];
            else if (i == 1) r.rot_y = acc[31:0];
            else r.rot_z = acc[31:0];
         end
         return r;
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      endtask

      function void note(qaar_pkg::req_type rq);
         pending.push_back(rotate(rq));
      endfunction

      task check(qaar_pkg::rsp_type got);
         qaar_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report("unexpected result", 1, 0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.rot_x !== want.rot_x) report("rot_x", got.rot_x, want.rot_x);
         if (got.rot_y !== want.rot_y) report("rot_y", got.rot_y, want.rot_y);
         if (got.rot_z !== want.rot_z) report("rot_z", got.rot_z, want.rot_z);
         if (got.axis_zero !== want.axis_zero)
            report("axis_zero", got.axis_zero, want.axis_zero);
         if (got.saturated !== want.saturated)
            report("saturated", got.saturated, want.saturated);
      endtask
   endclass

   rotation_scoreboard board;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note(req_data);
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.saturated) sat_seen++;
            if (rsp_data.axis_zero) zero_seen++;
            board.check(rsp_data);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             board.pending.size() == 0 && !req_valid)
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
         if (idle_count >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task send(qaar_pkg::req_type rq, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   function logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(131072)) - 65536);
         2: return 32'h1 << $urandom_range(31);
         3: return ~(32'h1 << $urandom_range(31));
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   function qaar_pkg::req_type rand_req();
      qaar_pkg::req_type rq;
      rq.axis_x = rand_coord();
      rq.axis_y = rand_coord();
      rq.axis_z = rand_coord();
      if ($urandom_range(15) == 0) rq = '{default: '0};
      rq.vec_x = rand_coord();
      rq.vec_y = rand_coord();
      rq.vec_z = rand_coord();
      rq.turn_angle = 24'($urandom);
      return rq;
   endfunction

   function qaar_pkg::req_type make(int ax, int ay, int az, int vx, int vy, int vz, int ang);
      qaar_pkg::req_type rq;
      rq.axis_x = ax; rq.axis_y = ay; rq.axis_z = az;
      rq.vec_x = vx; rq.vec_y = vy; rq.vec_z = vz;
      rq.turn_angle = ang[23:0];
      return rq;
   endfunction

   int idle_pct[4] = '{0, 77, 0, 15};
   int stall_pct[4] = '{0, 0, 77, 15};
   qaar_pkg::req_type directed[$];

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      rsp_stall_pct = 0;
      idle_count = 0;
      sat_seen = 0;
      zero_seen = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(make(0, 0, 0, 32'h7fffffff, 32'h80000000, 12345, 1647099));
      directed.push_back(make(0, 0, 0, -1, 0, 1, -8388608));
      directed.push_back(make(0, 0, 65536, 65536, 0, 0, 1647099));
      directed.push_back(make(0, 0, 65536, 32'h7fffffff, 32'h7fffffff, 0, 823550));
      directed.push_back(make(0, 0, 1, 32'h80000000, 32'h80000000, 0, -823550));
      directed.push_back(make(32'h80000000, 0, 0, 0, 65536, 0, 8388607));
      directed.push_back(make(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              65536, 65536, 65536, -8388608));
      directed.push_back(make(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 32'h7fffffff, 4000000));
      directed.push_back(make(1, 0, 0, 0, 65536, 0, -4000000));
      directed.push_back(make(0, 1, 0, 0, 0, 65536, 3294199));
      directed.push_back(make(0, 0, -1, 65536, 0, 0, -3294199));
      directed.push_back(make(65536, 65536, 0, 65536, -65536, 65536, 0));
      directed.push_back(make(-65536, 131072, 196608, 1, -1, 1, 1));
      directed.push_back(make(3, 4, 0, 32'h7fffffff, 0, 32'h80000000, 2000000));
      directed.push_back(make(32'h7fffffff, 0, 0, 32'h7fffffff, 32'h7fffffff,
                              32'h7fffffff, 6588397));
      directed.push_back(make(-1, -1, -1, -65536, -65536, -65536, -6588397));
      foreach (directed[k]) send(directed[k], 0);
      drain();

      for (int p = 0; p < 4; p++) begin
         rsp_stall_pct = stall_pct[p];
         for (int n = 0; n < 160; n++) send(rand_req(), idle_pct[p]);
         // sender holds off until the pipe is empty
         drain();
      end
      rsp_stall_pct = 0;

      $display("checked %0d results over four handshake phases", board.checked);
      $display("%0d with zero axis, %0d clipped", zero_seen, sat_seen);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
